// ----- hw/rtl/lgi_pkg.sv -----
package lgi_pkg;

	localparam int unsigned MAX_POINTS_DEF = 16;
	localparam int unsigned WEIGHT_W = 63;
	localparam int unsigned MAG_W = 33;
	localparam int unsigned PROD_W = 96;
	localparam int unsigned DIV_STEPS = PROD_W;
	localparam int unsigned DIV_CW = $clog2(DIV_STEPS);

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(64'd1 << 32);
	localparam logic [PROD_W-1:0] WEIGHT_MAX = PROD_W'(64'd1 << 62);
	localparam logic [63:0] TERM_MAX = 64'd1 << 56;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_EVAL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_DUP   = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	typedef struct packed {
		logic    take_item;
		logic    mem_wr;
		logic    lat_xa;
		logic    lat_j;
		logic    ld_fac;
		logic    ld_term;
		logic    mul0;
		logic    mul1;
		logic    div_step;
		logic    div_end;
		logic    term_add;
		logic    acc_clr;
		logic    out_load;
		logic    out_eval;
		status_t out_code;
	} dp_cmd_t;

	typedef struct packed {
		logic x_match;
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- hw/rtl/lgi_if.sv -----
interface lgi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] x_value;
	logic [31:0] y_value;

	modport source (output valid, output operation, output x_value, output y_value,
		input ready);
	modport sink (input valid, input operation, input x_value, input y_value,
		output ready);
endinterface

interface lgi_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] interp_value;
	logic [2:0]  status;
	logic [4:0]  node_count;

	modport source (output valid, output interp_value, output status, output node_count,
		input ready);
	modport sink (input valid, input interp_value, input status, input node_count,
		output ready);
endinterface

// ----- hw/rtl/lgi_datapath.sv -----
module lgi_datapath import lgi_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dp_cmd_t        cmd,
	output dp_sts_t        sts,
	input  logic [AW-1:0]  rd_addr,
	input  logic [AW-1:0]  wr_addr,
	input  logic [CW-1:0]  n_held,
	input  logic [31:0]    x_in,
	input  logic [31:0]    y_in,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_value,
	output logic [2:0]     out_status,
	output logic [4:0]     out_count
);

	logic [31:0] mem_x [MAX_POINTS];
	logic [31:0] mem_y [MAX_POINTS];
	logic [31:0] rdx_q, rdy_q;
	logic [31:0] xq_q, yin_q, xa_q, xj_q, yj_q;
	logic [MAG_W-1:0] m_q, d_q, rem_q;
	logic neg_q, sat_q;
	logic [WEIGHT_W-1:0] wm_q;
	logic [PROD_W-1:0] prod_q;
	logic signed [63:0] acc_q;
	logic out_valid_q;
	logic [31:0] out_value_q;
	logic [2:0] out_status_q;
	logic [4:0] out_count_q;

	logic signed [MAG_W-1:0] dn, dd, ys;
	logic [64:0] pp_lo, pp_hi;
	logic [MAG_W:0] div_sh;
	logic div_bit;
	logic [63:0] tm_raw, tm;
	logic [31:0] fin_value;
	logic fin_sat;
	logic [31:0] ncnt;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_x[wr_addr] <= xq_q;
			mem_y[wr_addr] <= yin_q;
		end
		rdx_q <= mem_x[rd_addr];
		rdy_q <= mem_y[rd_addr];
	end

	always_comb begin
		dn = $signed({xq_q[31], xq_q}) - $signed({rdx_q[31], rdx_q});
		dd = $signed({xj_q[31], xj_q}) - $signed({rdx_q[31], rdx_q});
		ys = $signed({yj_q[31], yj_q});
		pp_lo = {33'b0, wm_q[31:0]} * {32'b0, m_q};
		pp_hi = {34'b0, wm_q[62:32]} * {32'b0, m_q};
		div_sh = {rem_q, prod_q[PROD_W-1]};
		div_bit = div_sh >= {1'b0, d_q};
		tm_raw = prod_q[95:32];
		tm = (tm_raw > TERM_MAX) ? TERM_MAX : tm_raw;
		fin_sat = 1'b0;
		fin_value = acc_q[31:0];
		if (acc_q > 64'sd2147483647) begin
			fin_value = 32'h7fffffff;
			fin_sat = 1'b1;
		end else if (acc_q < -64'sd2147483648) begin
			fin_value = 32'h80000000;
			fin_sat = 1'b1;
		end
		ncnt = 32'(n_held);
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			xq_q <= x_in;
			yin_q <= y_in;
		end
		if (cmd.lat_xa) begin
			xa_q <= rdx_q;
		end
		if (cmd.lat_j) begin
			xj_q <= rdx_q;
			yj_q <= rdy_q;
			wm_q <= WEIGHT_ONE;
			neg_q <= 1'b0;
		end
		if (cmd.ld_fac) begin
			m_q <= dn[MAG_W-1] ? MAG_W'(-dn) : MAG_W'(dn);
			d_q <= dd[MAG_W-1] ? MAG_W'(-dd) : MAG_W'(dd);
			neg_q <= neg_q ^ dn[MAG_W-1] ^ dd[MAG_W-1];
		end
		if (cmd.ld_term) begin
			m_q <= ys[MAG_W-1] ? MAG_W'(-ys) : MAG_W'(ys);
			neg_q <= neg_q ^ yj_q[31];
		end
		if (cmd.mul0) begin
			prod_q <= PROD_W'(pp_lo);
		end
		if (cmd.mul1) begin
			prod_q <= prod_q + (PROD_W'(pp_hi) << 32);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			// Restoring division: the dividend shifts out on top, quotient bits in below.
			rem_q <= div_bit ? MAG_W'(div_sh - {1'b0, d_q}) : div_sh[MAG_W-1:0];
			prod_q <= {prod_q[PROD_W-2:0], div_bit};
		end
		if (cmd.div_end) begin
			wm_q <= (prod_q > WEIGHT_MAX) ? WEIGHT_MAX[WEIGHT_W-1:0] : prod_q[WEIGHT_W-1:0];
		end
		if (cmd.out_load) begin
			out_value_q <= cmd.out_eval ? fin_value : 32'd0;
			out_status_q <= cmd.out_eval ? ((sat_q || fin_sat) ? ST_SAT : ST_OK) : cmd.out_code;
			out_count_q <= ncnt[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc_clr) begin
				acc_q <= '0;
				sat_q <= 1'b0;
			end
			if (cmd.div_end && prod_q > WEIGHT_MAX) begin
				sat_q <= 1'b1;
			end
			if (cmd.term_add) begin
				acc_q <= neg_q ? acc_q - $signed(tm) : acc_q + $signed(tm);
				if (tm_raw > TERM_MAX) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.x_match = (rdx_q == xa_q);
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_status = out_status_q;
	assign out_count = out_count_q;

endmodule

// ----- hw/rtl/lgi_ctrl.sv -----
module lgi_ctrl import lgi_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    operation,
	output dp_cmd_t       cmd,
	input  dp_sts_t       sts,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr,
	output logic [CW-1:0] n_held
);

	typedef enum logic [17:0] {
		S_IDLE     = 18'h00001,
		S_APPEND   = 18'h00002,
		S_DUP_A    = 18'h00004,
		S_DUP_AL   = 18'h00008,
		S_DUP_BI   = 18'h00010,
		S_DUP_BC   = 18'h00020,
		S_J_RD     = 18'h00040,
		S_J_LAT    = 18'h00080,
		S_I_CHK    = 18'h00100,
		S_I_LAT    = 18'h00200,
		S_MUL0     = 18'h00400,
		S_MUL1     = 18'h00800,
		S_DIV      = 18'h01000,
		S_DIV_END  = 18'h02000,
		S_TERM_LD  = 18'h04000,
		S_TERM_ADD = 18'h08000,
		S_DONE     = 18'h10000,
		S_SPARE    = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] n_q, n_d, a_q, a_d, b_q, b_d, j_q, j_d, i_q, i_d;
	logic [DIV_CW-1:0] cnt_q, cnt_d;
	logic term_q, term_d, eval_q, eval_d;
	status_t code_q, code_d;
	op_t op;

	assign op = op_t'(operation);

	always_comb begin
		state_d = state_q;
		n_d = n_q;
		a_d = a_q;
		b_d = b_q;
		j_d = j_q;
		i_d = i_q;
		cnt_d = cnt_q;
		term_d = term_q;
		eval_d = eval_q;
		code_d = code_q;
		cmd = '0;
		cmd.out_code = code_q;
		cmd.out_eval = eval_q;
		rd_addr = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					cmd.acc_clr = 1'b1;
					eval_d = 1'b0;
					code_d = ST_OK;
					state_d = S_DONE;
					unique case (op)
						OP_CLEAR: n_d = '0;
						OP_APPEND: begin
							if (n_q == CW'(MAX_POINTS)) begin
								code_d = ST_FULL;
							end else begin
								state_d = S_APPEND;
							end
						end
						OP_EVAL: begin
							if (n_q == '0) begin
								code_d = ST_EMPTY;
							end else if (n_q == CW'(1)) begin
								j_d = '0;
								state_d = S_J_RD;
							end else begin
								a_d = CW'(1);
								state_d = S_DUP_A;
							end
						end
						default: ;
					endcase
				end
			end
			S_APPEND: begin
				cmd.mem_wr = 1'b1;
				n_d = CW'(n_q + 1'b1);
				state_d = S_DONE;
			end
			S_DUP_A: begin
				rd_addr = a_q[AW-1:0];
				state_d = S_DUP_AL;
			end
			S_DUP_AL: begin
				cmd.lat_xa = 1'b1;
				b_d = '0;
				state_d = S_DUP_BI;
			end
			S_DUP_BI: begin
				rd_addr = b_q[AW-1:0];
				state_d = S_DUP_BC;
			end
			S_DUP_BC: begin
				if (sts.x_match) begin
					code_d = ST_DUP;
					state_d = S_DONE;
				end else if (CW'(b_q + 1'b1) == a_q) begin
					if (CW'(a_q + 1'b1) == n_q) begin
						j_d = '0;
						state_d = S_J_RD;
					end else begin
						a_d = CW'(a_q + 1'b1);
						state_d = S_DUP_A;
					end
				end else begin
					b_d = CW'(b_q + 1'b1);
					state_d = S_DUP_BI;
				end
			end
			S_J_RD: begin
				rd_addr = j_q[AW-1:0];
				state_d = S_J_LAT;
			end
			S_J_LAT: begin
				cmd.lat_j = 1'b1;
				i_d = '0;
				state_d = S_I_CHK;
			end
			S_I_CHK: begin
				rd_addr = i_q[AW-1:0];
				if (i_q == n_q) begin
					state_d = S_TERM_LD;
				end else if (i_q == j_q) begin
					i_d = CW'(i_q + 1'b1);
				end else begin
					state_d = S_I_LAT;
				end
			end
			S_I_LAT: begin
				cmd.ld_fac = 1'b1;
				term_d = 1'b0;
				state_d = S_MUL0;
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				cnt_d = '0;
				state_d = term_q ? S_TERM_ADD : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = DIV_CW'(cnt_q + 1'b1);
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				cmd.div_end = 1'b1;
				i_d = CW'(i_q + 1'b1);
				state_d = S_I_CHK;
			end
			S_TERM_LD: begin
				cmd.ld_term = 1'b1;
				term_d = 1'b1;
				state_d = S_MUL0;
			end
			S_TERM_ADD: begin
				cmd.term_add = 1'b1;
				if (CW'(j_q + 1'b1) == n_q) begin
					eval_d = 1'b1;
					state_d = S_DONE;
				end else begin
					j_d = CW'(j_q + 1'b1);
					state_d = S_J_RD;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			a_q <= '0;
			b_q <= '0;
			j_q <= '0;
			i_q <= '0;
			cnt_q <= '0;
			term_q <= 1'b0;
			eval_q <= 1'b0;
			code_q <= ST_OK;
		end else begin
			state_q <= state_d;
			n_q <= n_d;
			a_q <= a_d;
			b_q <= b_d;
			j_q <= j_d;
			i_q <= i_d;
			cnt_q <= cnt_d;
			term_q <= term_d;
			eval_q <= eval_d;
			code_q <= code_d;
		end
	end

	assign wr_addr = n_q[AW-1:0];
	assign n_held = n_q;

endmodule

// ----- hw/rtl/lagrange_interpolator.sv -----
// Clear, append and an evaluation of an empty table load their result from the DONE state,
// append after writing the node in APPEND. An evaluation over N >= 1 nodes is paced by the
// 96-step one-bit-per-cycle divider and the split multiplier (MUL0, MUL1) that all factors
// share. One item is worked at a time; the next transfer is taken in the cycle after the
// result is loaded, later while the previous result still waits.
// Reset empties the node table and drops any pending result; node storage is not cleared.
module lagrange_interpolator import lgi_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	lgi_in_if.sink   in_ch,
	lgi_out_if.source out_ch
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [CW-1:0] n_held;

	lgi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.operation(in_ch.operation),
		.cmd      (cmd),
		.sts      (sts),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.n_held   (n_held)
	);

	lgi_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.n_held    (n_held),
		.x_in      (in_ch.x_value),
		.y_in      (in_ch.y_value),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_value (out_ch.interp_value),
		.out_status(out_ch.status),
		.out_count (out_ch.node_count)
	);

endmodule

// ----- verif/lgi_checker.sv -----
`timescale 1ns / 100ps

module lgi_checker import lgi_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	lgi_in_if   in_ch,
	lgi_out_if  out_ch,
	output int  errors,
	output int  pending,
	output int  results_seen,
	output int  evals_seen,
	output int  flagged_seen
);

	typedef struct {
		logic [31:0] value;
		status_t     code;
		logic [4:0]  count;
	} interp_result_t;

	localparam logic [127:0] WEIGHT_CAP = 128'd1 << 62;

	logic signed [31:0] table_x [MAX_POINTS];
	logic signed [31:0] table_y [MAX_POINTS];
	int unsigned        table_n;
	interp_result_t     awaited_q [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Weights keep 32 fraction bits; every factor is multiplied in exactly and then
	// divided with truncation, so the 128-bit product never overflows.
	function automatic void interpolate(input logic signed [31:0] xq,
			output logic [31:0] value, output status_t code);
		logic signed [63:0] acc, dn, dd;
		logic [63:0]        wm, dn_m, dd_m, y_m, tm;
		logic [127:0]       prod, quot;
		bit                 neg, sat;
		value = '0;
		sat = 0;
		acc = '0;
		if (table_n == 0) begin
			code = ST_EMPTY;
			return;
		end
		for (int a = 0; a < table_n; a++)
			for (int b = 0; b < a; b++)
				if (table_x[a] == table_x[b]) begin
					code = ST_DUP;
					return;
				end
		for (int j = 0; j < table_n; j++) begin
			wm = 64'd1 << 32;
			neg = 0;
			for (int i = 0; i < table_n; i++) begin
				if (i == j)
					continue;
				dn = 64'(xq) - 64'(table_x[i]);
				dd = 64'(table_x[j]) - 64'(table_x[i]);
				neg ^= (dn < 0) ^ (dd < 0);
				dn_m = (dn < 0) ? -dn : dn;
				dd_m = (dd < 0) ? -dd : dd;
				prod = {64'd0, wm} * {64'd0, dn_m};
				quot = prod / {64'd0, dd_m};
				if (quot > WEIGHT_CAP) begin
					sat = 1;
					wm = WEIGHT_CAP[63:0];
				end else
					wm = quot[63:0];
			end
			neg ^= table_y[j] < 0;
			y_m = (table_y[j] < 0) ? -64'(table_y[j]) : 64'(table_y[j]);
			prod = {64'd0, wm} * {64'd0, y_m};
			if (prod[127:96] != 0) begin
				sat = 1;
				tm = TERM_MAX;
			end else begin
				tm = prod[95:32];
				if (tm > TERM_MAX) begin
					sat = 1;
					tm = TERM_MAX;
				end
			end
			acc += neg ? -$signed(tm) : $signed(tm);
		end
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
			sat = 1;
		end else if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
			sat = 1;
		end
		value = acc[31:0];
		code = sat ? ST_SAT : ST_OK;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		results_seen = 0;
		evals_seen = 0;
		flagged_seen = 0;
		table_n = 0;
	end

	always @(posedge clk) begin
		interp_result_t exp_r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			exp_r.value = '0;
			exp_r.code = ST_OK;
			case (op_t'(in_ch.operation))
				OP_CLEAR: table_n = 0;
				OP_APPEND: begin
					if (table_n >= MAX_POINTS)
						exp_r.code = ST_FULL;
					else begin
						table_x[table_n] = in_ch.x_value;
						table_y[table_n] = in_ch.y_value;
						table_n++;
					end
				end
				OP_EVAL: begin
					interpolate(in_ch.x_value, exp_r.value, exp_r.code);
					evals_seen++;
				end
				default: ;
			endcase
			exp_r.count = table_n[4:0];
			if (exp_r.code != ST_OK)
				flagged_seen++;
			awaited_q.insert(awaited_q.size(), exp_r);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (awaited_q.size() == 0) begin
				$display("%0t result transfer with nothing outstanding", $realtime);
				errors++;
			end else begin
				exp_r = awaited_q.pop_front();
				if (out_ch.interp_value !== exp_r.value)
					report("interp_value", out_ch.interp_value, exp_r.value);
				if (out_ch.status !== exp_r.code)
					report("status", 32'(out_ch.status), 32'(exp_r.code));
				if (out_ch.node_count !== exp_r.count)
					report("node_count", 32'(out_ch.node_count), 32'(exp_r.count));
			end
		end
		pending = awaited_q.size();
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb import lgi_pkg::*;;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending, results_seen, evals_seen, flagged_seen;
	int   send_idle_pct = 35;
	int   recv_idle_pct = 59;
	int   sent = 0;
	bit   hold_go = 0;
	bit   hold_done = 0;
	int   hold_cycles = 0;

	lgi_in_if  in_ch ();
	lgi_out_if out_ch ();

	lagrange_interpolator dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	lgi_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .pending(pending), .results_seen(results_seen),
		.evals_seen(evals_seen), .flagged_seen(flagged_seen));

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.operation = OP_CLEAR;
		in_ch.x_value = '0;
		in_ch.y_value = '0;
		out_ch.ready = 0;
	end

	// The receiver stalls at random, and once holds off for a long stretch so that
	// the block backs up and stops taking transfers.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			out_ch.ready <= 0;
			hold_cycles++;
			if (hold_cycles >= 400)
				hold_done <= 1;
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send(input op_t op, input logic [31:0] xv, input logic [31:0] yv);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.operation <= op;
		in_ch.x_value <= xv;
		in_ch.y_value <= yv;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value(input bit wide);
		if (wide || $urandom_range(9) == 0)
			return $urandom;
		return 32'($signed($urandom_range(65536 * 16)) - 65536 * 8);
	endfunction

	initial begin
		int n;
		logic [31:0] xs [16];
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, extremes, unknown code, repeated x, full table.
		send(OP_EVAL, 32'h0000_1000, '0);
		send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
		send(OP_EVAL, 32'h8000_0000, '0);
		send(OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
		send(OP_EVAL, '0, '0);
		send(OP_EVAL, 32'h7FFF_FFFF, '0);
		send(OP_APPEND, 32'h0001_0000, 32'h0003_0000);
		send(OP_EVAL, 32'h0000_8000, '0);
		send(OP_APPEND, 32'h0001_0000, 32'h0005_0000);
		send(OP_EVAL, 32'h0002_0000, '0);
		send(OP_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000);
		for (int k = 0; k < 16; k++)
			send(OP_APPEND, 32'((k - 8) * 65536), 32'((k * k - 40) * 4096));
		send(OP_APPEND, 32'h0040_0000, 32'h0001_0000);
		send(OP_EVAL, 32'h0000_4000, '0);
		send(OP_CLEAR, '0, '0);
		wait_idle();

		while (sent < 520) begin
			if (sent >= 350) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (sent >= 180) begin
				if (send_idle_pct == 35) begin
					// Let the pipeline run dry once before swapping the idle rates.
					wait_idle();
					send_idle_pct = 59;
					recv_idle_pct = 35;
				end
			end
			if (sent >= 400 && !hold_go) begin
				hold_go = 1;
				repeat (20) send(op_t'($urandom_range(1)), $urandom, $urandom);
			end
			if ($urandom_range(99) < 80) begin
				n = ($urandom_range(24) == 0) ? 16 : $urandom_range(5, 1);
				send(OP_CLEAR, $urandom, $urandom);
				for (int k = 0; k < n; k++) begin
					xs[k] = pick_value(0);
					if (k > 0 && $urandom_range(19) == 0)
						xs[k] = xs[$urandom_range(k - 1)];
					send(OP_APPEND, xs[k], pick_value($urandom_range(3) == 0));
				end
				if (n == 16 && $urandom_range(1))
					send(OP_APPEND, $urandom, $urandom);
				repeat ((n == 16) ? 1 : $urandom_range(3, 1))
					send(OP_EVAL, ($urandom_range(3) == 0) ? xs[$urandom_range(n - 1)]
						: pick_value($urandom_range(4) == 0), $urandom);
			end else if ($urandom_range(9) == 0 || chk.table_n >= 6)
				send(OP_CLEAR, $urandom, $urandom);
			else
				send(op_t'($urandom_range(3)), $urandom, $urandom);
		end
		wait_idle();
		repeat (50) @(posedge clk);
		$display("Run covered %0d results, %0d of them evaluations, %0d with a flagged status.",
			results_seen, evals_seen, flagged_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#300ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
